### design/pli_pkg.sv
// pli_pkg: shared constants, operation codes and the controller command type
// for the positional list block. No dependencies.
`default_nettype none

package pli_pkg;

    localparam int CAPACITY   = 32;
    localparam int ITEM_WIDTH = 32;

    localparam int FUNC_W  = 2;
    localparam int POS_W   = 6;
    localparam int FIELD_W = 32;
    localparam int LEN_W   = 6;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    localparam logic [FUNC_W-1:0] FUNC_RETRIEVE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE   = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } pli_cmd_t;

endpackage

`default_nettype wire

### design/pli_ctrl.sv
// pli_ctrl: transaction sequencing for the positional list.
// Depends on pli_pkg for the command struct.
`default_nettype none

module pli_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pli_pkg::pli_cmd_t     cmd
);
    import pli_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);
    assign cmd.load = s_valid && s_ready;
    assign cmd.exec = (state_reg == ST_EXEC);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while result pending");
    a_load_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec)
        else $error("accepted transaction not executed");
    a_exec_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid)
        else $error("executed transaction produced no result");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before acceptance");
`endif

endmodule

`default_nettype wire

### design/pli_datapath.sv
// pli_datapath: shift-chain entry storage, count, range checks and result register.
// Depends on pli_pkg for sizes, operation codes and the command struct.
`default_nettype none

module pli_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pli_pkg::pli_cmd_t             cmd,
    input  wire logic [pli_pkg::FUNC_W-1:0]    s_func,
    input  wire logic [pli_pkg::POS_W-1:0]     s_position,
    input  wire logic [pli_pkg::FIELD_W-1:0]   s_item_in,
    output logic                               m_success,
    output logic [pli_pkg::FIELD_W-1:0]        m_item_out,
    output logic [pli_pkg::LEN_W-1:0]          m_length
);
    import pli_pkg::*;

    logic [FUNC_W-1:0]     func_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [ITEM_WIDTH-1:0] item_reg;

    logic [ITEM_WIDTH-1:0] entries_reg  [CAPACITY];
    logic [ITEM_WIDTH-1:0] entries_next [CAPACITY];
    logic [ITEM_WIDTH-1:0] up_w         [CAPACITY];
    logic [ITEM_WIDTH-1:0] dn_w         [CAPACITY];

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               success_reg;
    logic               success_next;
    logic [FIELD_W-1:0] item_out_reg;
    logic [FIELD_W-1:0] item_out_next;
    logic [LEN_W-1:0]   length_reg;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_m1;
    logic [IDX_W-1:0] idx;
    logic             pos_nz;
    logic             in_list;
    logic             ins_ok;
    logic             del_ok;
    logic             rd_ok;

    // neighbor taps of the shift chain
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_tap
            if (g == 0) begin : g_first
                assign up_w[g] = entries_reg[g];
            end else begin : g_rest
                assign up_w[g] = entries_reg[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign dn_w[g] = entries_reg[g];
            end else begin : g_body
                assign dn_w[g] = entries_reg[g+1];
            end
        end
    endgenerate

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign idx     = pos_m1[IDX_W-1:0];
    assign pos_nz  = (pos_reg != '0);
    assign in_list = pos_nz && (pos_ext <= cnt_ext);

    assign rd_ok  = (func_reg == FUNC_RETRIEVE) && in_list;
    assign del_ok = (func_reg == FUNC_DELETE) && in_list;
    assign ins_ok = (func_reg == FUNC_INSERT) && pos_nz
                    && (pos_ext <= cnt_ext + CMP_W'(1))
                    && (cnt_ext < CMP_W'(CAPACITY));

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            entries_next[i] = entries_reg[i];
            if (ins_ok) begin
                if (IDX_W'(i) == idx) begin
                    entries_next[i] = item_reg;
                end else if (IDX_W'(i) > idx) begin
                    entries_next[i] = up_w[i];
                end
            end else if (del_ok) begin
                if (IDX_W'(i) >= idx) begin
                    entries_next[i] = dn_w[i];
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ins_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (del_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
        success_next  = rd_ok || ins_ok || del_ok;
        item_out_next = rd_ok ? FIELD_W'(entries_reg[idx]) : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            pos_reg  <= s_position;
            item_reg <= ITEM_WIDTH'(s_item_in);
        end
        if (cmd.exec) begin
            entries_reg  <= entries_next;
            success_reg  <= success_next;
            item_out_reg <= item_out_next;
            length_reg   <= LEN_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    assign m_success  = success_reg;
    assign m_item_out = item_out_reg;
    assign m_length   = length_reg;

endmodule

`default_nettype wire

### design/positional_list_insert_delete.sv
// positional_list_insert_delete: top level of the positional list block.
// Depends on pli_pkg, pli_ctrl and pli_datapath.
//
//  channel | direction | handshake          | fields
//  s_      | in        | s_valid / s_ready  | s_func, s_position, s_item_in
//  m_      | out       | m_valid / m_ready  | m_success, m_item_out, m_length
//
// Transactions run one at a time: accept, execute, present result.
// The execute state moves every entry at or past the position by one slot in
// the shift chain, so insert and delete finish within that state.
// Synchronous active-low reset empties the list; entries are not cleared.
// A result held by m_ready low blocks the next input until it is taken.
`default_nettype none

module positional_list_insert_delete (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pli_pkg::FUNC_W-1:0]    s_func,
    input  wire logic [pli_pkg::POS_W-1:0]     s_position,
    input  wire logic [pli_pkg::FIELD_W-1:0]   s_item_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_success,
    output logic [pli_pkg::FIELD_W-1:0]        m_item_out,
    output logic [pli_pkg::LEN_W-1:0]          m_length
);
    import pli_pkg::*;

    pli_cmd_t cmd;

    pli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pli_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_func     (s_func),
        .s_position (s_position),
        .s_item_in  (s_item_in),
        .m_success  (m_success),
        .m_item_out (m_item_out),
        .m_length   (m_length)
    );

endmodule

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking testbench for positional_list_insert_delete.
// Holds a scoreboard class with its own list model; plain tasks drive the
// s_ channel and a separate process throttles m_ready. Depends on pli_pkg.
`default_nettype none

module tb_top;
    import pli_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_OPS   = 1400;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} op_mix_t;

    typedef struct packed {
        logic               success;
        logic [FIELD_W-1:0] item;
        logic [LEN_W-1:0]   length;
    } list_result_t;

    class list_scoreboard;
        logic [ITEM_WIDTH-1:0] slots [CAPACITY];
        int unsigned           depth;
        list_result_t          result_q[$];
        int unsigned           n_mismatch;

        function new();
            depth      = 0;
            n_mismatch = 0;
        endfunction

        // apply one accepted transaction to the list and queue its result
        function void note_input(logic [FUNC_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [FIELD_W-1:0] value);
            list_result_t r;
            r = '0;
            case (op)
                FUNC_RETRIEVE: begin
                    if (pos >= 1 && pos <= depth) begin
                        r.success = 1'b1;
                        r.item    = FIELD_W'(slots[pos-1]);
                    end
                end
                FUNC_INSERT: begin
                    if (pos >= 1 && pos <= depth + 1 && depth < CAPACITY) begin
                        for (int i = depth; i > int'(pos) - 1; i--)
                            slots[i] = slots[i-1];
                        slots[pos-1] = value[ITEM_WIDTH-1:0];
                        depth++;
                        r.success = 1'b1;
                    end
                end
                FUNC_DELETE: begin
                    if (pos >= 1 && pos <= depth) begin
                        for (int i = int'(pos) - 1; i + 1 < int'(depth); i++)
                            slots[i] = slots[i+1];
                        depth--;
                        r.success = 1'b1;
                    end
                end
                default: ;
            endcase
            r.length = LEN_W'(depth);
            result_q.push_back(r);
        endfunction

        function void flag(string what);
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $display("ERROR: %s", what);
        endfunction

        function void check_result(logic success, logic [FIELD_W-1:0] item,
                                   logic [LEN_W-1:0] length);
            list_result_t w;
            if (result_q.size() == 0) begin
                flag($sformatf("unexpected result success=%b item=%h length=%0d",
                               success, item, length));
                return;
            end
            w = result_q.pop_front();
            if (success !== w.success)
                flag($sformatf("success exp %b got %b", w.success, success));
            if (item !== w.item)
                flag($sformatf("item_out exp %h got %h", w.item, item));
            if (length !== w.length)
                flag($sformatf("length exp %0d got %0d", w.length, length));
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func;
    logic [POS_W-1:0]    s_position;
    logic [FIELD_W-1:0]  s_item_in;
    logic                m_valid;
    logic                m_ready;
    logic                m_success;
    logic [FIELD_W-1:0]  m_item_out;
    logic [LEN_W-1:0]    m_length;

    list_scoreboard sb = new();
    int unsigned    tx_idle_pct;
    int unsigned    rx_idle_pct;
    int unsigned    n_sent;
    int unsigned    quiet_cycles;
    bit             hold_done;

    positional_list_insert_delete dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_position (s_position),
        .s_item_in  (s_item_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_success  (m_success),
        .m_item_out (m_item_out),
        .m_length   (m_length)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // offer one transaction, hold it until accepted, then maybe idle
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [FIELD_W-1:0] value);
        s_func     <= op;
        s_position <= pos;
        s_item_in  <= value;
        s_valid    <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, pos, value);
        n_sent++;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_random(input op_mix_t mix);
        logic [FUNC_W-1:0] op;
        logic [POS_W-1:0]  pos;
        int unsigned       roll;
        int unsigned       top;
        roll = $urandom_range(99);
        case (mix)
            MODE_FILL:
                op = roll < 65 ? FUNC_INSERT : roll < 85 ? FUNC_RETRIEVE :
                     roll < 97 ? FUNC_DELETE : FUNC_UNUSED;
            MODE_DRAIN:
                op = roll < 65 ? FUNC_DELETE : roll < 85 ? FUNC_RETRIEVE :
                     roll < 97 ? FUNC_INSERT : FUNC_UNUSED;
            default:
                op = roll < 35 ? FUNC_INSERT : roll < 65 ? FUNC_RETRIEVE :
                     roll < 95 ? FUNC_DELETE : FUNC_UNUSED;
        endcase
        top  = (op == FUNC_INSERT) ? sb.depth + 1 : sb.depth;
        roll = $urandom_range(99);
        if (roll < 80 && top >= 1)
            pos = POS_W'($urandom_range(top, 1));
        else if (roll < 90)
            pos = POS_W'(top + 1);
        else
            pos = POS_W'($urandom_range(63, 0));
        send_op(op, pos, $urandom);
    endtask

    // receiver: random back-pressure plus one long hold
    initial begin
        m_ready <= 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_success, m_item_out, m_length);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("positional_list_insert_delete: mismatch");
            $finish;
        end
    end

    initial begin
        op_mix_t mix;
        s_valid      <= 1'b0;
        s_func       <= FUNC_RETRIEVE;
        s_position   <= '0;
        s_item_in    <= '0;
        aresetn      <= 1'b0;
        tx_idle_pct  = 32;
        rx_idle_pct  = 77;
        n_sent       = 0;
        mix          = MODE_MIXED;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, bad positions, insert at ends and middle
        send_op(FUNC_RETRIEVE, 6'd1, 32'h0);
        send_op(FUNC_DELETE, 6'd1, 32'h0);
        send_op(FUNC_INSERT, 6'd0, 32'h1234_5678);
        send_op(FUNC_INSERT, 6'd2, 32'h1234_5678);
        send_op(FUNC_INSERT, 6'd1, 32'hFFFF_FFFF);
        send_op(FUNC_INSERT, 6'd2, 32'h0000_0000);
        send_op(FUNC_INSERT, 6'd1, 32'hA5A5_A5A5);
        send_op(FUNC_INSERT, 6'd2, 32'h5A5A_5A5A);
        for (int p = 1; p <= 5; p++)
            send_op(FUNC_RETRIEVE, POS_W'(p), 32'h0);
        send_op(FUNC_RETRIEVE, 6'd63, 32'hFFFF_FFFF);
        send_op(FUNC_UNUSED, 6'd1, 32'hFFFF_FFFF);
        send_op(FUNC_DELETE, 6'd5, 32'h0);
        send_op(FUNC_DELETE, 6'd2, 32'h0);
        send_op(FUNC_DELETE, 6'd3, 32'h0);
        send_op(FUNC_DELETE, 6'd1, 32'h0);
        send_op(FUNC_RETRIEVE, 6'd1, 32'h0);
        send_op(FUNC_DELETE, 6'd63, 32'h0);
        send_op(FUNC_INSERT, 6'd63, 32'hFFFF_FFFF);
        send_op(FUNC_DELETE, 6'd1, 32'h0);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS / 3) begin
                tx_idle_pct = 77;
                rx_idle_pct = 32;
            end else if (n == 2 * RANDOM_OPS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (n % 50 == 0)
                mix = op_mix_t'($urandom_range(2, 0));
            send_random(mix);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.n_mismatch == 0 && sb.pending() == 0)
            $display("positional_list_insert_delete: match");
        else
            $display("positional_list_insert_delete: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
